// ===== src/first_match_packet_filter_top_macros.svh =====
// Assertion macros shared by the packet filter RTL.
`ifndef FIRST_MATCH_PACKET_FILTER_TOP_MACROS_SVH
`define FIRST_MATCH_PACKET_FILTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/fmpf_pkg.sv =====
`default_nettype none

package fmpf_pkg;

   localparam int RULES_PER_CHAIN = 64;
   localparam int CHAIN_NUM       = 3;
   localparam int TOTAL_RULES     = RULES_PER_CHAIN * CHAIN_NUM;
   localparam int ADDR_W          = $clog2(TOTAL_RULES);
   localparam int IDX_W           = $clog2(RULES_PER_CHAIN + 1);
   localparam int CHAIN_W         = 2;
   localparam int CSR_IDX_W       = 2;

   // request codes
   localparam logic [1:0] REQ_EVAL  = 2'd0;
   localparam logic [1:0] REQ_ADD   = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;
   localparam logic [1:0] REQ_BAD   = 2'd3;

   // status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;

   // verdicts / rule actions
   localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
   localparam logic [1:0] VERDICT_DROP   = 2'd1;
   localparam logic [1:0] VERDICT_REJECT = 2'd2;
   localparam logic [1:0] ACT_INVALID    = 2'd3;

   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [15:0] MIN_IP_LEN = 16'd20;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  chain;
      logic [1:0]  action;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] src_netmask;
      logic [31:0] dst_ip;
      logic [31:0] dst_netmask;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic [15:0] pkt_len;
      logic [3:0]  header_words;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  verdict;
      logic [6:0]  rule_index;
      logic [6:0]  rules_in_chain;
      logic [31:0] hit_packets;
      logic [47:0] hit_bytes;
   } rsp_item_type;

   // one stored rule
   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] src_netmask;
      logic [31:0] dst_ip;
      logic [31:0] dst_netmask;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic [1:0]  action;
      logic [7:0]  protocol;
   } rule_type;

   // hit counters of one rule
   typedef struct packed {
      logic [31:0] pkts;
      logic [47:0] bytes;
   } cnt_type;

   localparam int RULE_W = $bits(rule_type);
   localparam int CNT_W  = $bits(cnt_type);

   // update command broadcast to the chain cells
   typedef struct packed {
      logic               fill_we;
      logic [CHAIN_W-1:0] chain;
      logic [IDX_W-1:0]   fill;
      logic               pol_we;
      logic [CSR_IDX_W-1:0] pol_idx;
      logic               policy;
   } cell_cmd_type;

   // lookup result passed along the cell row
   typedef struct packed {
      logic [IDX_W-1:0] fill;
      logic             policy;
   } chain_info_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_RESP
   } fsm_state_type;

endpackage

`default_nettype wire

// ===== src/first_match_packet_filter_top.sv =====
// First-match packet filter.
// Request channel (req_valid/req_stall/req_data) takes evaluate, add-rule
// and flush items; every item yields exactly one result on the response
// channel (rsp_valid/rsp_stall/rsp_data). Policy bits are written through
// the csr_ port, which is always ready.
// Add, flush and invalid items pass through S_EXEC and then S_RESP before
// rsp_valid. An evaluate walks the chain's rule memory one rule per cycle
// from slot 0 and stops at the first hit or after the last filled slot; a
// short packet or an empty chain skips the walk.
// The rule walk over the single read port of the rule memory sets the
// rate; one item is processed at a time.
// A new request is taken while a finished result still sits in the output
// register. If the receiver stalls, the result holds and a following item
// waits in its final cycle until the output register frees up.
// Reset (synchronous, active high) empties all chains and clears policies;
// no memory clearing pass is needed.
`default_nettype none
`include "first_match_packet_filter_top_macros.svh"

module first_match_packet_filter_top
   import fmpf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_item_type         req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_item_type         rsp_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic                 csr_data
);

   fsm_state_type    state_ff, state_in;
   req_item_type     req_ff, req_in;
   rsp_item_type     res_ff, res_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic             rd_vld_ff, rd_vld_in;

   cell_cmd_type     cmd;
   chain_info_type   link [CHAIN_NUM+1];
   chain_info_type   sel_info;

   logic              rule_we, cnt_we, mem_re;
   logic [ADDR_W-1:0] waddr, raddr, base;
   logic [RULE_W-1:0] rule_rd;
   logic [CNT_W-1:0]  cnt_rd;
   rule_type          rule_q, rule_wr;
   cnt_type           cnt_q, cnt_wr, cnt_inc;

   logic              chain_ok, short_pkt, takes_ports, scan_hit, scan_last;
   logic [15:0]       dport;
   logic [6:0]        hdr_need;
   logic              proto_ok, src_ok, dst_ok, port_ok;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // row of chain cells: fill count and policy per chain
   assign link[0] = '0;
   for (genvar g = 0; g < CHAIN_NUM; g++) begin : g_cell
      fmpf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CHAIN_W'(g)),
         .cmd       (cmd),
         .sel_chain (req_ff.chain),
         .info_in   (link[g]),
         .info_out  (link[g+1])
      );
   end
   assign sel_info = link[CHAIN_NUM];

   // rule and counter memories, same address map
   fmpf_ram #(.WIDTH(RULE_W), .DEPTH(TOTAL_RULES)) u_rule_ram (
      .clock (clock),
      .we    (rule_we),
      .waddr (waddr),
      .wdata (rule_wr),
      .re    (mem_re),
      .raddr (raddr),
      .rdata (rule_rd)
   );

   fmpf_ram #(.WIDTH(CNT_W), .DEPTH(TOTAL_RULES)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (waddr),
      .wdata (cnt_wr),
      .re    (mem_re),
      .raddr (raddr),
      .rdata (cnt_rd)
   );

   assign rule_q = rule_type'(rule_rd);
   assign cnt_q  = cnt_type'(cnt_rd);

   // request decode
   assign base      = ADDR_W'(int'(req_ff.chain) * RULES_PER_CHAIN);
   assign chain_ok  = (req_ff.req_type != REQ_BAD) && (int'(req_ff.chain) < CHAIN_NUM);
   assign short_pkt = req_ff.pkt_len < MIN_IP_LEN;
   // header plus both ports, up to 64 bytes
   assign hdr_need  = {1'b0, req_ff.header_words, 2'b00} + 7'd4;
   assign takes_ports = (req_ff.protocol == PROTO_TCP || req_ff.protocol == PROTO_UDP)
                        && (req_ff.pkt_len >= 16'(hdr_need));
   assign dport = takes_ports ? req_ff.port_high : 16'd0;

   // rule compare on the rule read last cycle
   assign proto_ok = (rule_q.protocol == 8'd0) || (rule_q.protocol == req_ff.protocol);
   assign src_ok   = (rule_q.src_ip == 32'd0) ||
                     ((req_ff.src_ip & rule_q.src_netmask) ==
                      (rule_q.src_ip & rule_q.src_netmask));
   assign dst_ok   = (rule_q.dst_ip == 32'd0) ||
                     ((req_ff.dst_ip & rule_q.dst_netmask) ==
                      (rule_q.dst_ip & rule_q.dst_netmask));
   assign port_ok  = (rule_q.port_low == 16'd0 && rule_q.port_high == 16'd0) ||
                     (dport >= rule_q.port_low && dport <= rule_q.port_high);
   assign scan_hit  = rd_vld_ff && proto_ok && src_ok && dst_ok && port_ok;
   assign scan_last = rd_vld_ff && (IDX_W'(rd_idx_ff + 1'b1) == sel_info.fill);

   assign cnt_inc.pkts  = cnt_q.pkts + 32'd1;
   assign cnt_inc.bytes = cnt_q.bytes + 48'(req_ff.pkt_len);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (chain_ok && req_ff.req_type == REQ_EVAL && !short_pkt &&
                sel_info.fill != '0) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      scan_idx_in  = scan_idx_ff;
      rd_idx_in    = rd_idx_ff;
      rd_addr_in   = rd_addr_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rule_we      = 1'b0;
      cnt_we       = 1'b0;
      mem_re       = 1'b0;
      waddr        = base + ADDR_W'(sel_info.fill);
      raddr        = base + ADDR_W'(scan_idx_ff);
      rule_wr      = '{src_ip: req_ff.src_ip, src_netmask: req_ff.src_netmask,
                       dst_ip: req_ff.dst_ip, dst_netmask: req_ff.dst_netmask,
                       port_low: req_ff.port_low, port_high: req_ff.port_high,
                       action: req_ff.action, protocol: req_ff.protocol};
      cnt_wr       = '0;
      cmd          = '0;

      // policy writes go straight to the cells
      cmd.pol_we  = csr_valid;
      cmd.pol_idx = csr_index;
      cmd.policy  = csr_data;
      cmd.chain   = req_ff.chain;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         S_EXEC: begin
            res_in = '{status: STS_INVALID, verdict: VERDICT_ACCEPT,
                       rule_index: 7'(RULES_PER_CHAIN), rules_in_chain: 7'd0,
                       hit_packets: 32'd0, hit_bytes: 48'd0};
            scan_idx_in = '0;
            if (chain_ok) begin
               res_in.rules_in_chain = 7'(sel_info.fill);
               case (req_ff.req_type)
                  REQ_EVAL: begin
                     res_in.status  = STS_OK;
                     res_in.verdict = short_pkt ? VERDICT_ACCEPT : {1'b0, sel_info.policy};
                  end
                  REQ_ADD: begin
                     if (req_ff.action == ACT_INVALID) begin
                        res_in.status = STS_INVALID;
                     end else if (sel_info.fill >= IDX_W'(RULES_PER_CHAIN)) begin
                        res_in.status = STS_FULL;
                     end else begin
                        rule_we               = 1'b1;
                        cnt_we                = 1'b1;
                        cmd.fill_we           = 1'b1;
                        cmd.fill              = IDX_W'(sel_info.fill + 1'b1);
                        res_in.status         = STS_OK;
                        res_in.rule_index     = 7'(sel_info.fill);
                        res_in.rules_in_chain = 7'(sel_info.fill + 1'b1);
                     end
                  end
                  REQ_FLUSH: begin
                     cmd.fill_we           = 1'b1;
                     cmd.fill              = '0;
                     res_in.status         = STS_OK;
                     res_in.rules_in_chain = 7'd0;
                  end
                  default: res_in.status = STS_INVALID;
               endcase
            end
         end
         S_SCAN: begin
            // issue the next read while rules remain and no hit is seen
            if (scan_idx_ff < sel_info.fill && !scan_hit) begin
               mem_re      = 1'b1;
               scan_idx_in = IDX_W'(scan_idx_ff + 1'b1);
               rd_idx_in   = scan_idx_ff;
               rd_addr_in  = raddr;
               rd_vld_in   = 1'b1;
            end
            // first hit: bump counters and report the rule
            if (scan_hit) begin
               cnt_we             = 1'b1;
               waddr              = rd_addr_ff;
               cnt_wr             = cnt_inc;
               res_in.verdict     = rule_q.action;
               res_in.rule_index  = 7'(rd_idx_ff);
               res_in.hit_packets = cnt_inc.pkts;
               res_in.hit_bytes   = cnt_inc.bytes;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      rd_addr_ff  <= rd_addr_in;
   end

   `ASSERT_IMPLIES(a_scan_bound, clock, reset, state_ff == S_SCAN, scan_idx_ff <= sel_info.fill)
   `ASSERT_IMPLIES(a_cnt_write, clock, reset, cnt_we, (state_ff == S_SCAN && rd_vld_ff) || (state_ff == S_EXEC && req_ff.req_type == REQ_ADD))
   `ASSERT_NEXT(a_hit_ends_scan, clock, reset, state_ff == S_SCAN && scan_hit, state_ff == S_RESP)
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_RESP))

endmodule

`default_nettype wire

// ===== src/fmpf_ram.sv =====
`default_nettype none

module fmpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/fmpf_cell.sv =====
`default_nettype none
`include "first_match_packet_filter_top_macros.svh"

module fmpf_cell
   import fmpf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [CHAIN_W-1:0] cell_id,
   input  wire cell_cmd_type       cmd,
   input  wire logic [CHAIN_W-1:0] sel_chain,
   input  wire chain_info_type     info_in,
   output      chain_info_type     info_out
);

   logic [IDX_W-1:0] fill_ff, fill_in;
   logic             policy_ff, policy_in;

   // per-chain fill and policy updates
   always_comb begin
      fill_in   = fill_ff;
      policy_in = policy_ff;
      if (cmd.fill_we && cmd.chain == cell_id) begin
         fill_in = cmd.fill;
      end
      if (cmd.pol_we && CHAIN_W'(cmd.pol_idx) == cell_id) begin
         policy_in = cmd.policy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         policy_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         policy_ff <= policy_in;
      end
   end

   // lookup: replace the neighbor's value when this cell is addressed
   always_comb begin
      info_out = info_in;
      if (sel_chain == cell_id) begin
         info_out.fill   = fill_ff;
         info_out.policy = policy_ff;
      end
   end

   `ASSERT_IMPLIES(a_fill_range, clock, reset, 1'b1, fill_ff <= IDX_W'(RULES_PER_CHAIN))

endmodule

`default_nettype wire

// ===== verif/first_match_packet_filter_top_tb.sv =====
`timescale 1ns / 1ps

module first_match_packet_filter_top_tb
   import fmpf_pkg::*;
;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CSR_POL_INPUT = 0;
   localparam int CSR_POL_FORWARD = 1;
   localparam int CSR_POL_OUTPUT = 2;
   localparam int REQ_W = $bits(req_item_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic csr_data = 1'b0;

   first_match_packet_filter_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // shadow of the rule tables and policy bits
   rule_type shadow_rules [CHAIN_NUM][RULES_PER_CHAIN];
   logic [31:0] shadow_pkts [CHAIN_NUM][RULES_PER_CHAIN];
   logic [47:0] shadow_bytes [CHAIN_NUM][RULES_PER_CHAIN];
   int shadow_fill [CHAIN_NUM];
   logic shadow_policy [CHAIN_NUM];

   rsp_item_type pending_rsps[$];
   int mismatches = 0;
   int cycles = 0;
   bit long_hold = 0;
   bit stimulus_done = 0;

   function automatic bit addr_hit(logic [31:0] ip, logic [31:0] mask, logic [31:0] a);
      return ip == 0 || ((a & mask) == (ip & mask));
   endfunction

   // classifier behavior for one request
   function automatic rsp_item_type classify(req_item_type r);
      rsp_item_type o;
      int ch;
      int fill;
      logic [15:0] dport;
      rule_type ru;
      o = '0;
      o.status = STS_INVALID;
      o.verdict = VERDICT_ACCEPT;
      o.rule_index = 7'(RULES_PER_CHAIN);
      ch = r.chain;
      if (r.req_type == REQ_BAD || ch >= CHAIN_NUM) return o;
      fill = shadow_fill[ch];
      if (r.req_type == REQ_EVAL) begin
         o.status = STS_OK;
         o.verdict = {1'b0, shadow_policy[ch]};
         if (r.pkt_len < MIN_IP_LEN) begin
            o.verdict = VERDICT_ACCEPT;
         end else begin
            dport = 0;
            if ((r.protocol == PROTO_TCP || r.protocol == PROTO_UDP) &&
                r.pkt_len >= 32'(r.header_words) * 4 + 4)
               dport = r.port_high;
            for (int i = 0; i < fill; i++) begin
               ru = shadow_rules[ch][i];
               if (ru.protocol != 0 && ru.protocol != r.protocol) continue;
               if (!addr_hit(ru.src_ip, ru.src_netmask, r.src_ip)) continue;
               if (!addr_hit(ru.dst_ip, ru.dst_netmask, r.dst_ip)) continue;
               if ((ru.port_low != 0 || ru.port_high != 0) &&
                   (dport < ru.port_low || dport > ru.port_high)) continue;
               shadow_pkts[ch][i] += 1;
               shadow_bytes[ch][i] += 48'(r.pkt_len);
               o.verdict = ru.action;
               o.rule_index = 7'(i);
               o.hit_packets = shadow_pkts[ch][i];
               o.hit_bytes = shadow_bytes[ch][i];
               break;
            end
         end
      end else if (r.req_type == REQ_ADD) begin
         if (r.action == ACT_INVALID) begin
            o.status = STS_INVALID;
         end else if (fill >= RULES_PER_CHAIN) begin
            o.status = STS_FULL;
         end else begin
            ru.src_ip = r.src_ip; ru.src_netmask = r.src_netmask;
            ru.dst_ip = r.dst_ip; ru.dst_netmask = r.dst_netmask;
            ru.port_low = r.port_low; ru.port_high = r.port_high;
            ru.action = r.action; ru.protocol = r.protocol;
            shadow_rules[ch][fill] = ru;
            shadow_pkts[ch][fill] = 0;
            shadow_bytes[ch][fill] = 0;
            o.rule_index = 7'(fill);
            fill++;
            shadow_fill[ch] = fill;
            o.status = STS_OK;
         end
      end else begin
         for (int i = 0; i < RULES_PER_CHAIN; i++) begin
            shadow_pkts[ch][i] = 0;
            shadow_bytes[ch][i] = 0;
         end
         shadow_fill[ch] = 0;
         fill = 0;
         o.status = STS_OK;
      end
      o.rules_in_chain = 7'(fill);
      return o;
   endfunction

   // one request transfer; with has_fixed the typed expectation is checked too
   task automatic send_req(req_item_type r, bit has_fixed, rsp_item_type fixed);
      rsp_item_type e;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = classify(r);
      if (has_fixed && e != fixed) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed table row disagrees: table %h predictor %h", fixed, e);
      end
      pending_rsps.push_back(e);
      @(negedge clock);
   endtask

   task automatic idle_req(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_policy(int idx, bit v);
      csr_valid <= 1'b1;
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_policy[idx] = v;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_item_type make_req(logic [1:0] kind, logic [1:0] ch,
                                             logic [1:0] act);
      req_item_type r;
      r = '0;
      r.req_type = kind; r.chain = ch; r.action = act;
      return r;
   endfunction

   // fully random request bits
   function automatic req_item_type rand_item();
      return req_item_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom}));
   endfunction

   // random rule, biased toward wildcards and narrow masks so packets match
   function automatic req_item_type rand_rule(logic [1:0] ch);
      req_item_type r;
      r = rand_item();
      r.req_type = REQ_ADD;
      r.chain = ch;
      r.action = ($urandom_range(0, 15) == 0) ? ACT_INVALID : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
         0: r.protocol = 0;
         1: r.protocol = PROTO_TCP;
         2: r.protocol = PROTO_UDP;
         default: ;
      endcase
      if ($urandom_range(0, 2) == 0) r.src_ip = 0;
      else r.src_netmask = $urandom_range(0, 1) ? 32'hFF000000 : 32'h0;
      if ($urandom_range(0, 2) == 0) r.dst_ip = 0;
      else r.dst_netmask = $urandom_range(0, 1) ? 32'hF0000000 : 32'h0;
      if ($urandom_range(0, 2) == 0) begin
         r.port_low = 0; r.port_high = 0;
      end else if ($urandom_range(0, 4) != 0) begin
         r.port_low = 16'($urandom_range(0, 2000));
         r.port_high = r.port_low + 16'($urandom_range(0, 30000));
      end
      return r;
   endfunction

   function automatic req_item_type rand_packet(logic [1:0] ch);
      req_item_type r;
      r = rand_item();
      r.req_type = REQ_EVAL;
      r.chain = ch;
      case ($urandom_range(0, 4))
         0, 1: r.protocol = PROTO_TCP;
         2: r.protocol = PROTO_UDP;
         default: ;
      endcase
      if ($urandom_range(0, 2) != 0) r.dst_ip[27:0] = 0;
      if ($urandom_range(0, 3) != 0) r.port_high = 16'($urandom_range(0, 20000));
      if ($urandom_range(0, 3) != 0) r.pkt_len = 16'($urandom_range(20, 1500));
      else if ($urandom_range(0, 1)) r.pkt_len = 16'($urandom_range(0, 80));
      return r;
   endfunction

   task automatic random_burst(int n);
      int sent;
      req_item_type r;
      logic [1:0] ch;
      sent = 0;
      while (sent < n) begin
         // burst of items, then a random gap (sometimes none)
         for (int b = $urandom_range(1, 12); b > 0 && sent < n; b--) begin
            ch = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 19))
               0: r = make_req(REQ_FLUSH, ch, 2'($urandom));
               1: begin
                  r = rand_item();
                  r.req_type = REQ_BAD;
               end
               2, 3, 4, 5, 6: r = rand_rule(ch);
               default: r = rand_packet(ch);
            endcase
            send_req(r, 0, '0);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_req($urandom_range(1, 20));
      end
   endtask

   // response stall pattern, plus one long hold-off
   initial begin
      @(negedge clock);
      while (!stimulus_done) begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
            @(negedge clock);
         end
      end
      rsp_stall <= 1'b0;
   end

   // compare each accepted result to the oldest expectation
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            e = pending_rsps.pop_front();
            if (rsp_data.status !== e.status || rsp_data.verdict !== e.verdict ||
                rsp_data.rule_index !== e.rule_index ||
                rsp_data.rules_in_chain !== e.rules_in_chain ||
                rsp_data.hit_packets !== e.hit_packets ||
                rsp_data.hit_bytes !== e.hit_bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %h actual %h", e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   typedef struct {
      req_item_type item;
      bit has_fixed;
      rsp_item_type fixed;
   } table_row_type;

   initial begin
      table_row_type rows[$];
      table_row_type row;
      rsp_item_type none;
      req_item_type r;
      for (int c = 0; c < CHAIN_NUM; c++) begin
         shadow_fill[c] = 0;
         shadow_policy[c] = 1'b0;
         for (int i = 0; i < RULES_PER_CHAIN; i++) begin
            shadow_pkts[c][i] = 0;
            shadow_bytes[c][i] = 0;
         end
      end
      none = '0;
      none.rule_index = 7'(RULES_PER_CHAIN);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_policy(CSR_POL_INPUT, 1'b1);
      write_policy(CSR_POL_FORWARD, 1'b0);
      write_policy(CSR_POL_OUTPUT, 1'b1);

      // directed table
      row.item = make_req(REQ_EVAL, 2'd0, 2'd0); row.item.pkt_len = 16'd40;
      row.has_fixed = 1; row.fixed = none; row.fixed.verdict = VERDICT_DROP;
      rows.push_back(row);
      row.item = make_req(REQ_EVAL, 2'd2, 2'd0); row.item.pkt_len = 16'd19;
      row.fixed = none; rows.push_back(row);
      row.item = make_req(REQ_EVAL, 2'd3, 2'd0); row.item.pkt_len = 16'hFFFF;
      row.fixed = none; row.fixed.status = STS_INVALID; rows.push_back(row);
      row.item = '1; row.fixed = none; row.fixed.status = STS_INVALID; rows.push_back(row);
      row.item = make_req(REQ_ADD, 2'd0, ACT_INVALID);
      row.fixed = none; row.fixed.status = STS_INVALID; rows.push_back(row);
      row.item = make_req(REQ_ADD, 2'd3, VERDICT_DROP);
      row.fixed = none; row.fixed.status = STS_INVALID; rows.push_back(row);
      // wildcard rule: all zero fields
      row.item = make_req(REQ_ADD, 2'd1, VERDICT_REJECT);
      row.fixed = none; row.fixed.rule_index = 0; row.fixed.rules_in_chain = 1;
      rows.push_back(row);
      row.has_fixed = 0;
      // TCP rule with port range, empty range, full-mask address rule
      r = make_req(REQ_ADD, 2'd0, VERDICT_ACCEPT); r.protocol = PROTO_TCP;
      r.port_low = 16'd80; r.port_high = 16'd443; row.item = r; rows.push_back(row);
      r.port_low = 16'd500; r.port_high = 16'd100; r.protocol = 0; row.item = r; rows.push_back(row);
      r = make_req(REQ_ADD, 2'd0, VERDICT_REJECT); r.src_ip = '1; r.src_netmask = '1;
      r.dst_ip = 32'h0A000001; r.dst_netmask = 32'hFF000000; r.port_low = 16'hFFFF;
      r.port_high = 16'hFFFF; row.item = r; rows.push_back(row);
      // packets: in range, ports too short for header, max length, UDP max port
      r = make_req(REQ_EVAL, 2'd0, 2'd0); r.protocol = PROTO_TCP; r.port_high = 16'd80;
      r.pkt_len = 16'd24; r.header_words = 4'd5; row.item = r; rows.push_back(row);
      r.pkt_len = 16'd23; row.item = r; rows.push_back(row);
      r.header_words = 4'hF; r.pkt_len = 16'd64; r.port_high = 16'd443; row.item = r;
      rows.push_back(row);
      r = make_req(REQ_EVAL, 2'd0, 2'd0); r.protocol = PROTO_UDP; r.src_ip = '1;
      r.dst_ip = 32'h0AFFFFFF; r.port_low = '1; r.port_high = '1; r.pkt_len = '1;
      r.header_words = 4'hF; row.item = r; rows.push_back(row);
      row.item = r; rows.push_back(row);
      r.protocol = 8'hFF; row.item = r; rows.push_back(row);
      r = make_req(REQ_EVAL, 2'd1, 2'd0); r.pkt_len = 16'd20; row.item = r; rows.push_back(row);
      r = make_req(REQ_FLUSH, 2'd0, 2'd0); row.item = r;
      row.has_fixed = 1; row.fixed = none; rows.push_back(row);
      row.item = make_req(REQ_FLUSH, 2'd3, 2'd0);
      row.fixed = none; row.fixed.status = STS_INVALID; rows.push_back(row);

      foreach (rows[i]) send_req(rows[i].item, rows[i].has_fixed, rows[i].fixed);
      drain();

      // fill chain 2 to the limit, then overflow it
      for (int i = 0; i < RULES_PER_CHAIN + 2; i++) begin
         r = rand_rule(2'd2);
         r.action = 2'($urandom_range(0, 2));
         send_req(r, 0, '0);
      end
      long_hold = 1;
      for (int i = 0; i < 20; i++) send_req(rand_packet(2'd2), 0, '0);
      drain();

      write_policy(CSR_POL_INPUT, 1'b0);
      write_policy(CSR_POL_FORWARD, 1'b1);
      write_policy(CSR_POL_OUTPUT, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         random_burst(RANDOM_ITEMS / 4);
         drain();
         write_policy(CSR_POL_INPUT, 1'($urandom));
         write_policy(CSR_POL_FORWARD, 1'($urandom));
         write_policy(CSR_POL_OUTPUT, 1'($urandom));
      end

      stimulus_done = 1;
      drain();
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
